@@ sv/impedance_position_controller_assert.svh @@
// Assertion helpers used by the controller RTL.
`ifndef IMPEDANCE_POSITION_CONTROLLER_ASSERT_SVH
`define IMPEDANCE_POSITION_CONTROLLER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IPC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ipc assertion failed");

// Condition that must never be seen on a clock edge outside reset.
`define IPC_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ipc forbidden condition seen");

`endif

@@ sv/ipc_pkg.sv @@
package ipc_pkg;

	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam int unsigned DIV_W = 43;
	localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

	localparam logic [1:0] ADDR_STIFFNESS = 2'd0;
	localparam logic [1:0] ADDR_DAMPING = 2'd1;
	localparam logic [1:0] ADDR_LIMIT = 2'd2;
	localparam logic [1:0] ADDR_WEIGHT = 2'd3;

	typedef enum logic [1:0] {
		MUL_DIFF,
		MUL_FILT,
		MUL_STIFF,
		MUL_DAMP
	} mul_sel_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		mul_sel_t mul_sel;
		logic div_init;
		logic div_step;
		logic raw_sat;
		logic err_calc;
		logic smooth_upd;
		logic verr_calc;
		logic acc_load;
		logic acc_add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

@@ sv/impedance_position_controller.sv @@
// An accepted item steps through the states MUL_VEL to FIN, using the bit-serial
// velocity divider and the shared 33x25 multiplier, used four times per item; a
// new item is taken only in IDLE, once FIN has written the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low): gains, limit, filter weight, previous position and
// filtered velocity all clear to zero; no result is pending.
module impedance_position_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  target_position,
	input  logic signed [31:0]  target_velocity,
	input  logic signed [31:0]  measured_position,
	input  logic [15:0]         elapsed_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [24:0]  drive_voltage
);

	logic [23:0] stiffness_q;
	logic [23:0] damping_q;
	logic [23:0] limit_q;
	logic [16:0] weight_q;
	ipc_pkg::cmd_t cmd;
	ipc_pkg::sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= '0;
			damping_q <= '0;
			limit_q <= '0;
			weight_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				ipc_pkg::ADDR_STIFFNESS: stiffness_q <= pwdata[23:0];
				ipc_pkg::ADDR_DAMPING: damping_q <= pwdata[23:0];
				ipc_pkg::ADDR_LIMIT: limit_q <= pwdata[23:0];
				ipc_pkg::ADDR_WEIGHT: weight_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ipc_pkg::ADDR_STIFFNESS: prdata = {8'd0, stiffness_q};
			ipc_pkg::ADDR_DAMPING: prdata = {8'd0, damping_q};
			ipc_pkg::ADDR_LIMIT: prdata = {8'd0, limit_q};
			ipc_pkg::ADDR_WEIGHT: prdata = {15'd0, weight_q};
			default: prdata = '0;
		endcase
	end

	ipc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ipc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.target_position   (target_position),
		.target_velocity   (target_velocity),
		.measured_position (measured_position),
		.elapsed_ms        (elapsed_ms),
		.stiffness_gain    (stiffness_q),
		.damping_gain      (damping_q),
		.drive_limit       (limit_q),
		.filter_weight     (weight_q),
		.drive_voltage     (drive_voltage),
		.out_valid         (out_valid),
		.out_ready         (out_ready)
	);

endmodule

@@ sv/ipc_datapath.sv @@
module ipc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ipc_pkg::cmd_t       cmd,
	output ipc_pkg::sts_t       sts,
	input  logic signed [31:0]  target_position,
	input  logic signed [31:0]  target_velocity,
	input  logic signed [31:0]  measured_position,
	input  logic [15:0]         elapsed_ms,
	input  logic [23:0]         stiffness_gain,
	input  logic [23:0]         damping_gain,
	input  logic [23:0]         drive_limit,
	input  logic [16:0]         filter_weight,
	output logic signed [24:0]  drive_voltage,
	output logic                out_valid,
	input  logic                out_ready
);

	logic signed [31:0] tv_q;
	logic [15:0] ms_q;
	logic signed [31:0] last_q;
	logic signed [31:0] smooth_q;
	logic signed [32:0] diff_q;
	logic signed [32:0] perr_q;
	logic signed [32:0] err_q;
	logic signed [32:0] verr_q;
	logic signed [31:0] raw_q;
	logic signed [57:0] prod_q;
	logic signed [58:0] acc_q;
	logic neg_q;
	logic [ipc_pkg::DIV_W-1:0] dq_q;
	logic [15:0] rem_q;
	logic signed [24:0] drive_q;
	logic out_valid_q;

	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [57:0] prod;
	logic signed [57:0] prod_mag;
	logic [16:0] shifted;
	logic [17:0] trial;
	logic signed [31:0] raw_next;
	logic signed [42:0] smooth_sum;
	logic signed [31:0] smooth_next;
	logic signed [42:0] drive_full;
	logic signed [42:0] lim_pos;
	logic signed [24:0] drive_next;

	always_comb begin
		case (cmd.mul_sel)
			ipc_pkg::MUL_DIFF: begin
				mul_a = diff_q;
				mul_b = {15'd0, ipc_pkg::MS_PER_S};
			end
			ipc_pkg::MUL_FILT: begin
				mul_a = err_q;
				mul_b = {8'd0, filter_weight};
			end
			ipc_pkg::MUL_STIFF: begin
				mul_a = perr_q;
				mul_b = {1'b0, stiffness_gain};
			end
			default: begin
				mul_a = verr_q;
				mul_b = {1'b0, damping_gain};
			end
		endcase
	end

	assign prod = 58'(mul_a) * 58'(mul_b);
	assign prod_mag = prod_q[57] ? -prod_q : prod_q;

	// restoring divide, one quotient bit per cycle
	assign shifted = {rem_q, dq_q[ipc_pkg::DIV_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, ms_q};

	always_comb begin
		if (!neg_q) begin
			raw_next = (dq_q > 43'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_q[31:0]);
		end else begin
			raw_next = (dq_q > 43'h0_8000_0000) ? 32'sh8000_0000 : -$signed(dq_q[31:0]);
		end
	end

	assign smooth_sum = 43'(smooth_q) + 43'($signed(prod_q[57:16]));
	always_comb begin
		if (smooth_sum > 43'sh0_7FFF_FFFF) begin
			smooth_next = 32'sh7FFF_FFFF;
		end else if (smooth_sum < -43'sh0_8000_0000) begin
			smooth_next = 32'sh8000_0000;
		end else begin
			smooth_next = smooth_sum[31:0];
		end
	end

	assign drive_full = acc_q[58:16];
	assign lim_pos = {19'd0, drive_limit};
	always_comb begin
		if (drive_full > lim_pos) begin
			drive_next = {1'b0, drive_limit};
		end else if (drive_full < -lim_pos) begin
			drive_next = -$signed({1'b0, drive_limit});
		end else begin
			drive_next = drive_full[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			smooth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q <= measured_position;
			end
			if (cmd.smooth_upd) begin
				smooth_q <= smooth_next;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tv_q <= target_velocity;
			ms_q <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
			diff_q <= 33'(measured_position) - 33'(last_q);
			perr_q <= 33'(target_position) - 33'(measured_position);
		end
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
		if (cmd.div_init) begin
			neg_q <= prod_q[57];
			dq_q <= prod_mag[ipc_pkg::DIV_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q <= {dq_q[ipc_pkg::DIV_W-2:0], ~trial[17]};
			rem_q <= trial[17] ? shifted[15:0] : trial[15:0];
		end
		if (cmd.raw_sat) begin
			raw_q <= raw_next;
		end
		if (cmd.err_calc) begin
			err_q <= 33'(raw_q) - 33'(smooth_q);
		end
		if (cmd.verr_calc) begin
			verr_q <= 33'(tv_q) - 33'(smooth_q);
		end
		if (cmd.acc_load) begin
			acc_q <= 59'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + 59'(prod_q);
		end
		if (cmd.out_load) begin
			drive_q <= drive_next;
		end
	end

	assign drive_voltage = drive_q;
	assign out_valid = out_valid_q;
	assign sts.out_busy = out_valid_q & ~out_ready;

endmodule

@@ sv/ipc_controller.sv @@
`include "impedance_position_controller_assert.svh"

module ipc_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output ipc_pkg::cmd_t  cmd,
	input  ipc_pkg::sts_t  sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_VEL,
		ST_DIV_INIT,
		ST_DIV,
		ST_RAW,
		ST_ERR,
		ST_MUL_FILT,
		ST_SMOOTH,
		ST_VERR,
		ST_MUL_K,
		ST_MUL_B,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL_VEL;
				end
				ST_MUL_VEL: state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == ipc_pkg::DIV_LAST) state_q <= ST_RAW;
				end
				ST_RAW: state_q <= ST_ERR;
				ST_ERR: state_q <= ST_MUL_FILT;
				ST_MUL_FILT: state_q <= ST_SMOOTH;
				ST_SMOOTH: state_q <= ST_VERR;
				ST_VERR: state_q <= ST_MUL_K;
				ST_MUL_K: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_FIN;
				ST_FIN: begin
					// hold until the output register is free
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.mul_sel = ipc_pkg::MUL_DIFF;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MUL_VEL: cmd.mul_en = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_RAW: cmd.raw_sat = 1'b1;
			ST_ERR: cmd.err_calc = 1'b1;
			ST_MUL_FILT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = ipc_pkg::MUL_FILT;
			end
			ST_SMOOTH: cmd.smooth_upd = 1'b1;
			ST_VERR: cmd.verr_calc = 1'b1;
			ST_MUL_K: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = ipc_pkg::MUL_STIFF;
			end
			ST_MUL_B: begin
				cmd.acc_load = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = ipc_pkg::MUL_DAMP;
			end
			ST_SUM: cmd.acc_add = 1'b1;
			ST_FIN: cmd.out_load = ~sts.out_busy;
			default: cmd = '0;
		endcase
	end

	`IPC_ASSERT(a_accept_busy, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	`IPC_ASSERT(a_out_free, clk, arst_n, cmd.out_load |-> !sts.out_busy)
	`IPC_ASSERT(a_load_mul, clk, arst_n, cmd.load |=> (cmd.mul_en && cmd.mul_sel == ipc_pkg::MUL_DIFF))
	`IPC_ASSERT(a_div_count, clk, arst_n, cmd.div_step |-> cnt_q <= ipc_pkg::DIV_LAST)
	`IPC_NEVER(a_load_not_idle, clk, arst_n, cmd.load && state_q != ST_IDLE)

endmodule
